FILE: hdl/klc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// klc_pkg: shared types and constants for the knob level conditioner
// Register indexes, command codes, datapath operations, control bundles.
// ----------------------------------------------------------------------------
package klc_pkg;

  localparam int ADC_W     = 12;
  localparam int LVL_W     = 16;
  localparam int OFF_W     = 13;
  localparam int CFG_IDX_W = 3;
  localparam int DIV_W     = 28;
  localparam int DEN_W     = 16;
  localparam int DIV_CNT_W = 5;

  localparam logic [ADC_W-1:0] ADC_TOP = 12'd4095;

  // map divide by ADC_TOP as a reciprocal multiply, exact for any PROD_W-bit product
  localparam int PROD_W  = ADC_W + LVL_W;
  localparam int MAP_SH  = PROD_W + ADC_W;
  localparam int MAP_M_W = PROD_W + 1;
  localparam int MAP_P_W = PROD_W + MAP_M_W;
  localparam logic [MAP_M_W-1:0] MAP_MUL =
    MAP_M_W'(((64'd1 << MAP_SH) + 64'(ADC_TOP) - 64'd1) / 64'(ADC_TOP));

  localparam logic [CFG_IDX_W-1:0] REG_RED_MIN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RED_MAX   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GREEN_MIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GREEN_MAX = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DEADBAND  = 3'd4;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_ANCHOR = 1'b1;

  typedef logic [3:0] klc_op_t;
  localparam klc_op_t OP_NONE     = 4'd0;
  localparam klc_op_t OP_LOAD     = 4'd1;
  localparam klc_op_t OP_ACC      = 4'd2;
  localparam klc_op_t OP_RAW      = 4'd3;
  localparam klc_op_t OP_MAP_PREP = 4'd4;
  localparam klc_op_t OP_MAP_DIV  = 4'd5;
  localparam klc_op_t OP_MAP_FIN  = 4'd6;
  localparam klc_op_t OP_ANC_PREP = 4'd7;
  localparam klc_op_t OP_ANC_FIN  = 4'd8;

  typedef struct packed {
    klc_op_t op;
    logic    div_start;
  } klc_cmd_t;

  typedef struct packed {
    logic acc_full;
    logic anchor_zero;
    logic div_done;
  } klc_status_t;

endpackage

FILE: hdl/klc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// klc_div: restoring unsigned divider
// One quotient bit per cycle; quotient holds after done until the next start.
// ----------------------------------------------------------------------------
module klc_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [klc_pkg::DIV_W-1:0] num,
  input  logic [klc_pkg::DEN_W-1:0] den,
  output logic [klc_pkg::DIV_W-1:0] quo,
  output logic                      done
);
  import klc_pkg::*;

  localparam logic [DIV_CNT_W-1:0] CNT_LAST = DIV_CNT_W'(DIV_W - 1);

  logic [DEN_W-1:0]     rem_r;
  logic [DIV_W-1:0]     quo_r;
  logic [DEN_W-1:0]     den_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;
  logic [DEN_W:0]       shifted;
  logic [DEN_W:0]       diff;
  logic                 ge;

  assign shifted = {rem_r, quo_r[DIV_W-1]};
  assign ge      = shifted >= {1'b0, den_r};
  assign diff    = shifted - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= num;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
      quo_r <= {quo_r[DIV_W-2:0], ge};
    end
  end

  assign quo  = quo_r;
  assign done = done_r;

endmodule

FILE: hdl/klc_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// klc_datapath: registers, channel state and arithmetic
// Holds config, per-channel sums, counts and offsets; feeds the divider.
// ----------------------------------------------------------------------------
module klc_datapath #(
  parameter int NUM_SAMPLES = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [klc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [klc_pkg::LVL_W-1:0]     cfg_data,
  input  logic                          in_channel,
  input  logic [klc_pkg::ADC_W-1:0]     in_adc_sample,
  input  logic [klc_pkg::LVL_W-1:0]     in_target_level,
  input  klc_pkg::klc_cmd_t             cmd,
  output klc_pkg::klc_status_t          status,
  output logic                          out_channel,
  output logic [klc_pkg::LVL_W-1:0]     out_level
);
  import klc_pkg::*;

  localparam int SUM_W = ADC_W + $clog2(NUM_SAMPLES);
  localparam int CNT_W = (NUM_SAMPLES > 1) ? $clog2(NUM_SAMPLES) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_SAMPLES - 1);

  // average as a reciprocal multiply, exact for any SUM_W-bit total
  localparam int AVG_SH  = SUM_W + $clog2(NUM_SAMPLES);
  localparam int AVG_M_W = AVG_SH + 1;
  localparam int AVG_P_W = SUM_W + AVG_M_W;
  localparam logic [AVG_M_W-1:0] AVG_MUL =
    AVG_M_W'(((64'd1 << AVG_SH) + 64'(NUM_SAMPLES) - 64'd1) / 64'(NUM_SAMPLES));

  logic [LVL_W-1:0] min_r [2];
  logic [LVL_W-1:0] max_r [2];
  logic [LVL_W-1:0] db_r;
  logic [SUM_W-1:0] sum_r [2];
  logic [CNT_W-1:0] cnt_r [2];
  logic [OFF_W-1:0] off_r [2];

  logic              ch_r;
  logic [ADC_W-1:0]  adc_r;
  logic [LVL_W-1:0]  tgt_r;
  logic [SUM_W-1:0]  tot_r;
  logic [ADC_W-1:0]  raw_r;
  logic [LVL_W-1:0]  mag_r;
  logic              neg_r;
  logic [PROD_W-1:0] prod_r;
  logic [LVL_W-1:0]  mq_r;
  logic              out_ch_r;
  logic [LVL_W-1:0]  out_lvl_r;

  logic [SUM_W-1:0]   sum_new;
  logic [LVL_W-1:0]   lo;
  logic [LVL_W-1:0]   hi;
  logic               span_neg;
  logic [LVL_W-1:0]   mag;
  logic [AVG_P_W-1:0] avg_prod;
  logic [ADC_W-1:0]   avg;
  logic [MAP_P_W-1:0] map_prod;
  logic [DIV_W-1:0]   anc_prod;
  logic [DEN_W-1:0]   anc_den;
  logic [DIV_W-1:0]   quo;
  logic               div_done;
  logic [LVL_W-1:0]   map_val;
  logic [LVL_W-1:0]   lvl;
  logic [ADC_W-1:0]   anc_raw;
  logic [OFF_W-1:0]   anc_off;

  assign lo       = min_r[ch_r];
  assign hi       = max_r[ch_r];
  assign sum_new  = sum_r[ch_r] + SUM_W'(adc_r);
  assign span_neg = hi < lo;
  assign mag      = span_neg ? (lo - hi) : (hi - lo);
  assign avg_prod = AVG_P_W'(tot_r) * AVG_P_W'(AVG_MUL);
  assign avg      = avg_prod[AVG_SH +: ADC_W];
  assign map_prod = MAP_P_W'(prod_r) * MAP_P_W'(MAP_MUL);
  assign anc_prod = {12'd0, tgt_r - lo} * {16'd0, ADC_TOP};
  assign anc_den  = hi - lo;

  klc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (anc_prod),
    .den   (anc_den),
    .quo   (quo),
    .done  (div_done)
  );

  assign map_val = neg_r ? (lo - mq_r) : (lo + mq_r);
  assign lvl     = (map_val < db_r) ? '0 : map_val;
  assign anc_raw = status.anchor_zero ? '0 :
                   ((quo > DIV_W'(ADC_TOP)) ? ADC_TOP : quo[ADC_W-1:0]);
  assign anc_off = {1'b0, anc_raw} - {1'b0, adc_r};

  assign status.acc_full    = cnt_r[ch_r] == CNT_LAST;
  assign status.anchor_zero = (hi <= lo) || (tgt_r < lo);
  assign status.div_done    = div_done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r[0] <= '0;
      min_r[1] <= '0;
      max_r[0] <= LVL_W'(ADC_TOP);
      max_r[1] <= LVL_W'(ADC_TOP);
      db_r     <= '0;
      sum_r[0] <= '0;
      sum_r[1] <= '0;
      cnt_r[0] <= '0;
      cnt_r[1] <= '0;
      off_r[0] <= '0;
      off_r[1] <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_RED_MIN:   min_r[0] <= cfg_data;
          REG_RED_MAX:   max_r[0] <= cfg_data;
          REG_GREEN_MIN: min_r[1] <= cfg_data;
          REG_GREEN_MAX: max_r[1] <= cfg_data;
          REG_DEADBAND:  db_r     <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.op == OP_ACC) begin
        if (status.acc_full) begin
          sum_r[ch_r] <= '0;
          cnt_r[ch_r] <= '0;
        end else begin
          sum_r[ch_r] <= sum_new;
          cnt_r[ch_r] <= cnt_r[ch_r] + 1'b1;
        end
      end
      if (cmd.op == OP_ANC_FIN) begin
        off_r[ch_r] <= anc_off;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        ch_r  <= in_channel;
        adc_r <= in_adc_sample;
        tgt_r <= in_target_level;
      end
      OP_ACC: tot_r <= sum_new;
      OP_RAW: begin
        raw_r <= avg + off_r[ch_r][ADC_W-1:0];
        mag_r <= mag;
        neg_r <= span_neg;
      end
      OP_MAP_PREP: prod_r <= PROD_W'(raw_r) * PROD_W'(mag_r);
      OP_MAP_DIV:  mq_r   <= map_prod[MAP_SH +: LVL_W];
      OP_MAP_FIN: begin
        out_ch_r  <= ch_r;
        out_lvl_r <= lvl;
      end
      default: ;
    endcase
  end

  assign out_channel = out_ch_r;
  assign out_level   = out_lvl_r;

endmodule

FILE: hdl/klc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// klc_ctrl: sequencing state machine
// Steps each request through accumulate, divide, map or anchor phases.
// ----------------------------------------------------------------------------
module klc_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_command,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  klc_pkg::klc_status_t status,
  output klc_pkg::klc_cmd_t    cmd
);
  import klc_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_ACC      = 4'd1;
  localparam logic [3:0] S_RAW      = 4'd2;
  localparam logic [3:0] S_MAP_PREP = 4'd3;
  localparam logic [3:0] S_MAP_DIV  = 4'd4;
  localparam logic [3:0] S_MAP_FIN  = 4'd5;
  localparam logic [3:0] S_ANC_PREP = 4'd6;
  localparam logic [3:0] S_ANC_WAIT = 4'd7;
  localparam logic [3:0] S_ANC_FIN  = 4'd8;

  logic [3:0] state_r;
  logic [3:0] state_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic       out_free;

  assign in_ready  = state_r == S_IDLE;
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd.op        = OP_NONE;
    cmd.div_start = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = (in_command == CMD_ANCHOR) ? S_ANC_PREP : S_ACC;
        end
      end
      S_ACC: begin
        cmd.op    = OP_ACC;
        state_nxt = status.acc_full ? S_RAW : S_IDLE;
      end
      S_RAW: begin
        cmd.op    = OP_RAW;
        state_nxt = S_MAP_PREP;
      end
      S_MAP_PREP: begin
        cmd.op    = OP_MAP_PREP;
        state_nxt = S_MAP_DIV;
      end
      S_MAP_DIV: begin
        cmd.op    = OP_MAP_DIV;
        state_nxt = S_MAP_FIN;
      end
      S_MAP_FIN: begin
        if (out_free) begin
          cmd.op        = OP_MAP_FIN;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_ANC_PREP: begin
        cmd.op = OP_ANC_PREP;
        if (status.anchor_zero) begin
          state_nxt = S_ANC_FIN;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = S_ANC_WAIT;
        end
      end
      S_ANC_WAIT: if (status.div_done) state_nxt = S_ANC_FIN;
      S_ANC_FIN: begin
        cmd.op    = OP_ANC_FIN;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: hdl/knob_level_conditioner.sv
`timescale 1ns / 1ps
// Flow: a sample that does not close a batch holds the input only for the accumulate
// step; the closing sample passes accumulate, raw, map prep, map divide and map finish
// steps, the last held while an earlier level still waits in the output register. An
// anchor runs the bit-serial divider, or skips it when the range is empty or the target
// lies below its minimum. Only one request is in flight at a time.
// Reset (synchronous, active low) restores config defaults, clears sums, counts, offsets.
// ----------------------------------------------------------------------------
// knob_level_conditioner: two-channel knob averaging, offset and range mapping
// Controller sequences the datapath and its shared divider.
// ----------------------------------------------------------------------------
module knob_level_conditioner #(
  parameter int NUM_SAMPLES = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [klc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [klc_pkg::LVL_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_command,
  input  logic                          in_channel,
  input  logic [klc_pkg::ADC_W-1:0]     in_adc_sample,
  input  logic [klc_pkg::LVL_W-1:0]     in_target_level,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_channel,
  output logic [klc_pkg::LVL_W-1:0]     out_level
);
  import klc_pkg::*;

  klc_cmd_t    cmd;
  klc_status_t status;

  klc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_command),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .cmd        (cmd)
  );

  klc_datapath #(
    .NUM_SAMPLES (NUM_SAMPLES)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_channel      (in_channel),
    .in_adc_sample   (in_adc_sample),
    .in_target_level (in_target_level),
    .cmd             (cmd),
    .status          (status),
    .out_channel     (out_channel),
    .out_level       (out_level)
  );

endmodule

FILE: hdl/klc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// klc_checker: port-level assertions for the knob level conditioner
// Attached to the top level by bind.
// ----------------------------------------------------------------------------
module klc_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          in_command,
  input logic                          in_channel,
  input logic [klc_pkg::ADC_W-1:0]     in_adc_sample,
  input logic [klc_pkg::LVL_W-1:0]     in_target_level,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          out_channel,
  input logic [klc_pkg::LVL_W-1:0]     out_level
);
  import klc_pkg::*;

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_command) && $stable(in_channel)
      && $stable(in_adc_sample) && $stable(in_target_level))
    else $error("request changed while waiting");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_level) && $stable(out_channel))
    else $error("result changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while previous one in flight");

  a_no_result_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result appeared on request accept");

  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared while idle");

endmodule

bind knob_level_conditioner klc_checker u_klc_checker (.*);

FILE: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: knob level conditioner checker
// Drives sample and anchor requests on both knob channels under several range
// and deadband settings. A predictor tracks sums, counts and offsets per channel
// and queues the expected levels. A monitor compares each returned level.
// ----------------------------------------------------------------------------
module testbench;
  import klc_pkg::*;

  localparam int BATCH_LEN    = 16;
  localparam int FULL_SCALE   = int'(ADC_TOP);
  localparam int STALL_LIMIT  = 2000;
  localparam int QUIET_CYCLES = 100;

  typedef struct {
    logic             ch;
    logic [LVL_W-1:0] level;
  } level_result_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [LVL_W-1:0]     cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  logic                 in_command;
  logic                 in_channel;
  logic [ADC_W-1:0]     in_adc_sample;
  logic [LVL_W-1:0]     in_target_level;
  logic                 out_valid;
  logic                 out_ready;
  logic                 out_channel;
  logic [LVL_W-1:0]     out_level;

  logic [LVL_W-1:0]        range_lo [2];
  logic [LVL_W-1:0]        range_hi [2];
  logic [LVL_W-1:0]        deadband;
  int unsigned             sample_total [2];
  int                      sample_tally [2];
  logic signed [OFF_W-1:0] offset_mirror [2];

  level_result_t pending_levels [$];
  int            mismatch_count;
  int            stall_cycles;
  bit            stall_enable;

  knob_level_conditioner #(.NUM_SAMPLES(BATCH_LEN)) uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_command     (in_command),
    .in_channel     (in_channel),
    .in_adc_sample  (in_adc_sample),
    .in_target_level(in_target_level),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_channel    (out_channel),
    .out_level      (out_level)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  function automatic void predict_request(input logic cmd, input logic ch,
                                          input logic [ADC_W-1:0] adc,
                                          input logic [LVL_W-1:0] target);
    int            lo;
    int            hi;
    int            avg;
    int            wrapped;
    longint        anchor_raw;
    longint        mapped;
    level_result_t res;
    lo = range_lo[ch];
    hi = range_hi[ch];
    if (cmd == CMD_ANCHOR) begin
      if (hi <= lo || int'(target) < lo) begin
        anchor_raw = 0;
      end else begin
        anchor_raw = longint'(int'(target) - lo) * FULL_SCALE / (hi - lo);
      end
      if (anchor_raw > FULL_SCALE) begin
        anchor_raw = FULL_SCALE;
      end
      offset_mirror[ch] = OFF_W'(anchor_raw - longint'(adc));
    end else begin
      sample_total[ch] += adc;
      sample_tally[ch]++;
      if (sample_tally[ch] >= BATCH_LEN) begin
        avg = sample_total[ch] / BATCH_LEN;
        sample_total[ch] = 0;
        sample_tally[ch] = 0;
        wrapped = (avg + int'(offset_mirror[ch])) & FULL_SCALE;
        mapped = longint'(wrapped) * (hi - lo) / FULL_SCALE + lo;
        if (mapped < 0) begin
          mapped = 0;
        end
        if (mapped > 65535) begin
          mapped = 65535;
        end
        if (mapped < longint'(deadband)) begin
          mapped = 0;
        end
        res.ch = ch;
        res.level = mapped[LVL_W-1:0];
        pending_levels.push_back(res);
      end
    end
  endfunction

  task automatic send_request(input logic cmd, input logic ch,
                              input logic [ADC_W-1:0] adc,
                              input logic [LVL_W-1:0] target);
    @(negedge clk);
    while (stall_enable && $urandom_range(99) < 32) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_command      <= cmd;
    in_channel      <= ch;
    in_adc_sample   <= adc;
    in_target_level <= target;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_request(cmd, ch, adc, target);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [LVL_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    case (idx)
      REG_RED_MIN:   range_lo[0] = value;
      REG_RED_MAX:   range_hi[0] = value;
      REG_GREEN_MIN: range_lo[1] = value;
      REG_GREEN_MAX: range_hi[1] = value;
      REG_DEADBAND:  deadband = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // drop valid, drain results, then let any anchor still in the divider finish
  task automatic wait_quiet();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_levels.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic set_ranges(input logic [LVL_W-1:0] red_lo, input logic [LVL_W-1:0] red_hi,
                            input logic [LVL_W-1:0] green_lo,
                            input logic [LVL_W-1:0] green_hi,
                            input logic [LVL_W-1:0] band);
    wait_quiet();
    write_register(REG_RED_MIN, red_lo);
    write_register(REG_RED_MAX, red_hi);
    write_register(REG_GREEN_MIN, green_lo);
    write_register(REG_GREEN_MAX, green_hi);
    write_register(REG_DEADBAND, band);
  endtask

  task automatic test_offset_extremes();
    send_request(CMD_ANCHOR, 1'b0, '0, 16'hFFFF);
    for (int i = 0; i < BATCH_LEN; i++) begin
      if (i == BATCH_LEN / 2) begin
        send_request(CMD_ANCHOR, 1'b1, ADC_TOP, '0);
      end
      send_request(CMD_SAMPLE, 1'b0, ADC_TOP, LVL_W'($urandom_range(65535)));
    end
  endtask

  task automatic test_range_corners();
    set_ranges(16'hFFFF, 16'h0000, 16'd2000, 16'd3000, 16'd0);
    send_request(CMD_ANCHOR, 1'b0, ADC_TOP, 16'hFFFF);
    send_request(CMD_ANCHOR, 1'b1, 12'd100, 16'd1999);
    send_request(CMD_ANCHOR, 1'b1, '0, 16'd3000);
  endtask

  task automatic test_random_phase(input int count);
    logic             cmd;
    logic             ch;
    logic [ADC_W-1:0] adc;
    logic [LVL_W-1:0] target;
    int               pick;
    for (int i = 0; i < count; i++) begin
      cmd = ($urandom_range(99) < 12) ? CMD_ANCHOR : CMD_SAMPLE;
      ch = 1'($urandom_range(1));
      pick = $urandom_range(9);
      adc = (pick == 0) ? '0 : (pick == 1) ? ADC_TOP : ADC_W'($urandom_range(FULL_SCALE));
      if ($urandom_range(1) == 0) begin
        target = LVL_W'($urandom_range(65535));
      end else begin
        target = LVL_W'($urandom_range(range_lo[ch], range_hi[ch]));
      end
      send_request(cmd, ch, adc, target);
    end
  endtask

  always @(negedge clk) begin
    out_ready <= !stall_enable || ($urandom_range(99) >= 32);
  end

  always @(posedge clk) begin
    level_result_t due;
    if (rst_n && out_valid && out_ready) begin
      if (pending_levels.size() == 0) begin
        report_mismatch($sformatf("unexpected level %0d on channel %0d", out_level, out_channel));
      end else begin
        due = pending_levels.pop_front();
        if (out_channel !== due.ch) begin
          report_mismatch($sformatf("channel %0d, expected %0d", out_channel, due.ch));
        end
        if (out_level !== due.level) begin
          report_mismatch($sformatf("level %0d on channel %0d, expected %0d",
                                    out_level, due.ch, due.level));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    in_valid        = 1'b0;
    in_command      = CMD_SAMPLE;
    in_channel      = 1'b0;
    in_adc_sample   = '0;
    in_target_level = '0;
    stall_enable    = 1'b1;
    mismatch_count  = 0;
    deadband        = '0;
    for (int c = 0; c < 2; c++) begin
      range_lo[c]      = '0;
      range_hi[c]      = LVL_W'(FULL_SCALE);
      sample_total[c]  = 0;
      sample_tally[c]  = 0;
      offset_mirror[c] = '0;
    end
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_offset_extremes();
    test_range_corners();
    test_random_phase(60);

    set_ranges(16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0);
    stall_enable = 1'b0;
    test_random_phase(250);
    stall_enable = 1'b1;

    set_ranges(16'hFFFF, 16'd0, 16'd4095, 16'd0, 16'd0);
    test_random_phase(250);

    set_ranges(16'd1000, 16'd1000, 16'd0, 16'd4095, 16'hFFFF);
    test_random_phase(200);

    set_ranges(16'd1000, 16'd1100, 16'd500, 16'd60000, 16'd1050);
    test_random_phase(250);

    for (int p = 0; p < 2; p++) begin
      set_ranges(LVL_W'($urandom_range(65535)), LVL_W'($urandom_range(65535)),
                 LVL_W'($urandom_range(65535)), LVL_W'($urandom_range(65535)),
                 LVL_W'($urandom_range(4000)));
      test_random_phase(220);
    end

    wait_quiet();
    if (pending_levels.size() != 0) begin
      report_mismatch($sformatf("%0d levels never arrived", pending_levels.size()));
    end
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
